>>> rtl/salc_pkg.sv
// Shared types and constants for the set-associative LRU cache model.
`default_nettype none

package salc_pkg;

  localparam int unsigned WAYS_DEF   = 4;
  localparam int unsigned SETS_DEF   = 64;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned CNT_W      = 32;

  // set number before the modulo: index_bits is 3 bits, so at most 7 bits
  localparam int unsigned RAW_SET_W  = 7;
  localparam int unsigned RAW_SETS   = 1 << RAW_SET_W;

  // configuration field widths and reset values
  localparam int unsigned OFFS_W     = 5;
  localparam int unsigned IDXB_W     = 3;
  localparam int unsigned NWAY_W     = 3;
  localparam logic              POLICY_RST = 1'b0;
  localparam logic [OFFS_W-1:0] OFFS_RST   = 5'd4;
  localparam logic [IDXB_W-1:0] IDXB_RST   = 3'd6;
  localparam logic [NWAY_W-1:0] NWAY_RST   = 3'd4;

  localparam int unsigned CFG_AW     = 4;
  localparam int unsigned CFG_DW     = 32;

  typedef enum logic [1:0] {
    REG_WRITE_POLICY = 2'd0,
    REG_OFFSET_BITS  = 2'd1,
    REG_INDEX_BITS   = 2'd2,
    REG_WAYS_IN_USE  = 2'd3
  } cfg_reg_e_t;

  // result beat: hit, refs, hit total, miss total, memref total, zero pad
  localparam int unsigned REFS_W     = 2;
  localparam int unsigned OUT_USED_W = 1 + REFS_W + 3 * CNT_W;
  localparam int unsigned OUT_DW     = ((OUT_USED_W + 7) / 8) * 8;

  // one cache line's bookkeeping, kept in a single RAM word
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [TAG_W-1:0]   tag;
    logic               dirty;
    logic               valid;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/salc_ram.sv
// Generic single-port RAM with registered read data.
`default_nettype none

module salc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                      wdata,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> rtl/set_assoc_lru_cache_sim.sv
// Top level: set-associative cache model, true LRU, write-through or write-back.
// Sequence: PREP, SCAN over nways ways, LAST, UPD, then the result beat, where nways is
//   ways_in_use clamped to 1..WAYS; one way is read from the line RAM per cycle.
// Only one access is in flight (single-port line RAM, one way per read).
// Reset (synchronous, rst_n low): counters and registers to defaults, then a clearing
//   pass writes every line RAM word to zero, with in_tready low.
`default_nettype none

module set_assoc_lru_cache_sim #(
  parameter int unsigned WAYS = salc_pkg::WAYS_DEF,
  parameter int unsigned SETS = salc_pkg::SETS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // access channel
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [salc_pkg::ADDR_W-1:0]   in_tdata,   // [31:0] address
  input  wire logic                          in_tuser,   // [0] kind (1 write)
  // result channel
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [0] hit, [2:1] mem_refs_now, [34:3] hit_total, [66:35] miss_total,
  // [98:67] memref_total, [103:99] zero
  output logic [salc_pkg::OUT_DW-1:0]        out_tdata,
  // configuration port
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [salc_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [salc_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic      [salc_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                               cfg_pready
);

  localparam int unsigned LINES   = SETS * WAYS;
  localparam int unsigned LINE_AW = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned SET_W   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned ENTRY_W = $bits(salc_pkg::entry_t);
  localparam int unsigned CNT_W   = salc_pkg::CNT_W;

  // sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP  = 7'b0000010,  // address split, set modulo, base line
    ST_SCAN  = 7'b0000100,  // read way w, evaluate way w-1
    ST_LAST  = 7'b0001000,  // evaluate the last way
    ST_UPD   = 7'b0010000,  // line write-back, totals, result
    ST_HOLD  = 7'b0100000,  // result waits for the output register
    ST_CLEAR = 7'b1000000   // post-reset sweep of the line RAM
  } state_t;

  state_t state_r, state_nxt;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                          policy_r;
  logic [salc_pkg::OFFS_W-1:0]   offs_r;
  logic [salc_pkg::IDXB_W-1:0]   idxb_r;
  logic [salc_pkg::NWAY_W-1:0]   nway_r;
  logic                          cfg_wr;
  salc_pkg::cfg_reg_e_t          cfg_sel;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_sel    = salc_pkg::cfg_reg_e_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= salc_pkg::POLICY_RST;
      offs_r   <= salc_pkg::OFFS_RST;
      idxb_r   <= salc_pkg::IDXB_RST;
      nway_r   <= salc_pkg::NWAY_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        salc_pkg::REG_WRITE_POLICY: policy_r <= cfg_pwdata[0];
        salc_pkg::REG_OFFSET_BITS:  offs_r   <= cfg_pwdata[salc_pkg::OFFS_W-1:0];
        salc_pkg::REG_INDEX_BITS:   idxb_r   <= cfg_pwdata[salc_pkg::IDXB_W-1:0];
        salc_pkg::REG_WAYS_IN_USE:  nway_r   <= cfg_pwdata[salc_pkg::NWAY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    case (cfg_sel)
      salc_pkg::REG_WRITE_POLICY: cfg_prdata = salc_pkg::CFG_DW'(policy_r);
      salc_pkg::REG_OFFSET_BITS:  cfg_prdata = salc_pkg::CFG_DW'(offs_r);
      salc_pkg::REG_INDEX_BITS:   cfg_prdata = salc_pkg::CFG_DW'(idxb_r);
      salc_pkg::REG_WAYS_IN_USE:  cfg_prdata = salc_pkg::CFG_DW'(nway_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Access capture and address split
  // ---------------------------------------------------------------------------
  logic                          in_fire;
  logic                          kind_r;
  logic [salc_pkg::ADDR_W-1:0]   addr_r;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r <= in_tuser;
      addr_r <= in_tdata;
    end
  end

  // set number modulo SETS: constant table over all raw set numbers
  logic [SET_W-1:0] set_tab [salc_pkg::RAW_SETS];

  for (genvar g = 0; g < salc_pkg::RAW_SETS; g++) begin : g_set_tab
    localparam int unsigned SET_MOD = g % SETS;
    assign set_tab[g] = SET_W'(SET_MOD);
  end

  logic [salc_pkg::ADDR_W-1:0]    shifted;
  logic [salc_pkg::RAW_SET_W:0]   set_mask_w;
  logic [salc_pkg::RAW_SET_W-1:0] set_raw;
  logic [SET_W-1:0]               set_mod;
  logic [5:0]                     total_shift;
  logic [salc_pkg::TAG_W-1:0]     tag_calc;
  logic [WAY_W-1:0]               last_calc;

  assign shifted     = addr_r >> offs_r;
  assign set_mask_w  = (8'd1 << idxb_r) - 8'd1;
  assign set_raw     = shifted[salc_pkg::RAW_SET_W-1:0] &
                       set_mask_w[salc_pkg::RAW_SET_W-1:0];
  assign set_mod     = set_tab[set_raw];
  assign total_shift = {1'b0, offs_r} + {3'd0, idxb_r};
  assign tag_calc    = (total_shift >= 6'd32) ? '0 : (addr_r >> total_shift[4:0]);

  // ways in use: zero acts as one, above WAYS acts as WAYS
  always_comb begin
    if (nway_r == '0) begin
      last_calc = '0;
    end else if ({29'd0, nway_r} > 32'(WAYS)) begin
      last_calc = WAY_W'(WAYS - 1);
    end else begin
      last_calc = WAY_W'(nway_r - 3'd1);
    end
  end

  logic [salc_pkg::TAG_W-1:0] tag_r;
  logic [LINE_AW-1:0]         base_r;
  logic [WAY_W-1:0]           last_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      tag_r  <= tag_calc;
      base_r <= LINE_AW'(32'(set_mod) * 32'(WAYS));
      last_r <= last_calc;
    end
  end

  // ---------------------------------------------------------------------------
  // Way scan: one RAM read per cycle, one tag compare and one stamp compare
  // shared across the ways
  // ---------------------------------------------------------------------------
  logic [WAY_W-1:0]           w_r;
  logic [WAY_W-1:0]           ev_way_r;
  logic                       ev_vld_r;
  logic                       hit_r;
  logic [WAY_W-1:0]           hit_way_r;
  logic                       hit_dirty_r;
  logic                       inv_r;
  logic [WAY_W-1:0]           inv_way_r;
  logic                       have_r;
  logic [salc_pkg::STAMP_W-1:0] min_stamp_r;
  logic [WAY_W-1:0]           min_way_r;
  logic                       min_dirty_r;

  logic [ENTRY_W-1:0]         ram_rdata;
  salc_pkg::entry_t           ent;
  logic                       tag_eq;
  logic                       stamp_lt;

  assign ent      = salc_pkg::entry_t'(ram_rdata);
  assign tag_eq   = (ent.tag == tag_r);
  assign stamp_lt = (ent.stamp < min_stamp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_vld_r <= 1'b0;
    end else if (state_r == ST_SCAN) begin
      ev_vld_r <= 1'b1;
    end else begin
      ev_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PREP) begin
      w_r    <= '0;
      hit_r  <= 1'b0;
      inv_r  <= 1'b0;
      have_r <= 1'b0;
    end else begin
      if (state_r == ST_SCAN) begin
        w_r      <= w_r + WAY_W'(1);
        ev_way_r <= w_r;
      end
      if (ev_vld_r) begin
        // lowest matching valid way wins
        if (!hit_r && ent.valid && tag_eq) begin
          hit_r       <= 1'b1;
          hit_way_r   <= ev_way_r;
          hit_dirty_r <= ent.dirty;
        end
        // lowest invalid way is the first victim choice
        if (!inv_r && !ent.valid) begin
          inv_r     <= 1'b1;
          inv_way_r <= ev_way_r;
        end
        // strictly smaller stamp, so ties keep the lower way
        if (!have_r || stamp_lt) begin
          have_r      <= 1'b1;
          min_stamp_r <= ent.stamp;
          min_way_r   <= ev_way_r;
          min_dirty_r <= ent.dirty;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Update: line write, saturating totals, result beat
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0] acc_r, hits_r, miss_r, mref_r;
  logic [CNT_W-1:0] acc_inc, hits_inc, miss_inc, mref_inc;
  logic [CNT_W:0]   mref_sum;
  logic [1:0]       refs;
  logic             upd_we;
  logic [WAY_W-1:0] upd_way;
  salc_pkg::entry_t upd_ent;
  logic [salc_pkg::OUT_DW-1:0] res_calc, res_r;

  assign acc_inc  = (acc_r == '1) ? acc_r : acc_r + CNT_W'(1);
  assign hits_inc = (hits_r == '1) ? hits_r : hits_r + CNT_W'(1);
  assign miss_inc = (miss_r == '1) ? miss_r : miss_r + CNT_W'(1);
  assign mref_sum = {1'b0, mref_r} + (CNT_W + 1)'(refs);
  assign mref_inc = mref_sum[CNT_W] ? '1 : mref_sum[CNT_W-1:0];

  always_comb begin
    upd_ent.stamp = acc_inc;
    upd_ent.tag   = tag_r;
    upd_ent.valid = 1'b1;
    upd_ent.dirty = kind_r & policy_r;
    upd_we        = 1'b1;
    upd_way       = hit_way_r;
    refs          = 2'd1;
    if (hit_r) begin
      // write-through write hit leaves the dirty mark as it was
      upd_ent.dirty = (kind_r & policy_r) | hit_dirty_r;
      refs          = (kind_r & ~policy_r) ? 2'd1 : 2'd0;
    end else if (kind_r && !policy_r) begin
      // write-through write miss: no allocate
      upd_we = 1'b0;
    end else begin
      upd_way = inv_r ? inv_way_r : min_way_r;
      // dirty victim under write-back costs a writeback reference
      refs    = (policy_r && !inv_r && min_dirty_r) ? 2'd2 : 2'd1;
    end
  end

  assign res_calc = {(salc_pkg::OUT_DW - salc_pkg::OUT_USED_W)'(0), mref_inc,
                     (hit_r ? miss_r : miss_inc), (hit_r ? hits_inc : hits_r),
                     refs, hit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      hits_r <= '0;
      miss_r <= '0;
      mref_r <= '0;
    end else if (state_r == ST_UPD) begin
      acc_r  <= acc_inc;
      mref_r <= mref_inc;
      if (hit_r) begin
        hits_r <= hits_inc;
      end else begin
        miss_r <= miss_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_UPD) begin
      res_r <= res_calc;
    end
  end

  // ---------------------------------------------------------------------------
  // Line RAM: scan reads, update writes, clearing sweep
  // ---------------------------------------------------------------------------
  logic [LINE_AW-1:0] clr_idx_r;
  logic [LINE_AW-1:0] ram_addr;
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_wdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = upd_ent;
    ram_addr  = base_r + LINE_AW'(w_r);
    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        ram_addr  = clr_idx_r;
      end
      ST_UPD: begin
        ram_we   = upd_we;
        ram_addr = base_r + LINE_AW'(upd_way);
      end
      default: ;
    endcase
  end

  salc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (LINES)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (state_r == ST_CLEAR) begin
      clr_idx_r <= clr_idx_r + LINE_AW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register and sequencer
  // ---------------------------------------------------------------------------
  logic                        out_tvalid_r;
  logic [salc_pkg::OUT_DW-1:0] out_tdata_r;
  logic                        out_free;
  logic                        out_load;

  assign out_free   = ~out_tvalid_r | out_tready;
  assign out_load   = out_free & ((state_r == ST_UPD) | (state_r == ST_HOLD));
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= (state_r == ST_UPD) ? res_calc : res_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_SCAN;
      ST_SCAN:  if (w_r == last_r) state_nxt = ST_LAST;
      ST_LAST:  state_nxt = ST_UPD;
      ST_UPD:   state_nxt = out_free ? ST_IDLE : ST_HOLD;
      ST_HOLD:  if (out_free) state_nxt = ST_IDLE;
      ST_CLEAR: if (clr_idx_r == LINE_AW'(LINES - 1)) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // one access in flight: the beat after an accepted access is never taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("access accepted while another is in flight");

  // a hit never costs a writeback, so never two references
  a_hit_refs: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[2:1] != 2'd2)
    else $error("hit reported with two memory references");

  // line RAM written only by the clearing sweep or the update step
  a_ram_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_CLEAR) || (state_r == ST_UPD))
    else $error("line RAM written outside clear or update");

  // a new result is loaded only when the previous beat is gone or leaving
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("pending result beat overwritten");

endmodule

`default_nettype wire
